// ===== design/json_string_unescape_assert.svh =====
// Assertion macros used by the checker file.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    // Decode state carried between input bytes.
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_cnt;
        logic [15:0] code_point;
    } t_dec_state;

    // One result item, without the end-of-run marker.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       truncated;
    } t_result;

    localparam int unsigned MaxResults = 3;

    // All results caused by one input byte.
    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [1:0]               count;
    } t_dec_out;

    localparam t_dec_state DEC_STATE_RESET = '{mode: MODE_NORMAL, hex_cnt: 2'd0,
                                               code_point: 16'h0000};

endpackage

// ===== design/jsu_if.sv =====
// Input channel: one raw string byte or an end-of-stream mark per transaction.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, data_byte, stream_end, input ready);
    modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

// Output channel: one decoded result per transaction.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       truncated;
    logic       last_of_run;

    modport source (output valid, out_byte, byte_valid, string_end, truncated, last_of_run,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, string_end, truncated, last_of_run,
                    output ready);
endinterface

// ===== design/jsu_decoder.sv =====
// Per-byte decode: next state and up to three results.
module jsu_decoder (
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  jsu_pkg::t_dec_state i_state,
    output jsu_pkg::t_dec_state o_state,
    output jsu_pkg::t_dec_out   o_out
);

    localparam logic [7:0]  CHAR_QUOTE     = 8'h22;
    localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CHAR_U         = 8'h75;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [5:0]  UTF8_MASK      = 6'h3F;
    localparam logic [15:0] CP_TWO_MIN     = 16'h0080;
    localparam logic [15:0] CP_THREE_MIN   = 16'h0800;

    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) begin
            v = h[3:0];
        end else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46)) begin
            v = h[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] e);
        logic [7:0] c;
        case (e)
            8'h62:   c = 8'h08;
            8'h66:   c = 8'h0C;
            8'h6E:   c = 8'h0A;
            8'h72:   c = 8'h0D;
            8'h74:   c = 8'h09;
            default: c = e;
        endcase
        return c;
    endfunction

    function automatic jsu_pkg::t_result byte_res(input logic [7:0] b);
        jsu_pkg::t_result r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    logic [15:0] cp_next;

    assign cp_next = {i_state.code_point[11:0], hex_value(i_byte)};

    always_comb begin
        o_state = i_state;
        o_out   = '0;
        if (i_end) begin
            o_out.res[0].truncated = 1'b1;
            o_out.count            = 2'd1;
            o_state                = jsu_pkg::DEC_STATE_RESET;
        end else begin
            unique case (i_state.mode)
                jsu_pkg::MODE_ESCAPE: begin
                    if (i_byte == CHAR_U) begin
                        o_state.mode       = jsu_pkg::MODE_HEX;
                        o_state.hex_cnt    = 2'd0;
                        o_state.code_point = 16'h0000;
                    end else begin
                        o_out.res[0]  = byte_res(escape_char(i_byte));
                        o_out.count   = 2'd1;
                        o_state.mode  = jsu_pkg::MODE_NORMAL;
                    end
                end
                jsu_pkg::MODE_HEX: begin
                    if (i_state.hex_cnt == 2'd3) begin
                        // Fourth digit: emit UTF-8 and start over.
                        if (cp_next < CP_TWO_MIN) begin
                            o_out.res[0] = byte_res(cp_next[7:0]);
                            o_out.count  = 2'd1;
                        end else if (cp_next < CP_THREE_MIN) begin
                            o_out.res[0] = byte_res(UTF8_LEAD2 | {3'b000, cp_next[10:6]});
                            o_out.res[1] = byte_res(UTF8_CONT | {2'b00, cp_next[5:0] & UTF8_MASK});
                            o_out.count  = 2'd2;
                        end else begin
                            o_out.res[0] = byte_res(UTF8_LEAD3 | {4'b0000, cp_next[15:12]});
                            o_out.res[1] = byte_res(UTF8_CONT | {2'b00, cp_next[11:6] & UTF8_MASK});
                            o_out.res[2] = byte_res(UTF8_CONT | {2'b00, cp_next[5:0] & UTF8_MASK});
                            o_out.count  = 2'd3;
                        end
                        o_state = jsu_pkg::DEC_STATE_RESET;
                    end else begin
                        o_state.code_point = cp_next;
                        o_state.hex_cnt    = i_state.hex_cnt + 2'd1;
                    end
                end
                default: begin
                    if (i_byte == CHAR_QUOTE) begin
                        o_out.res[0].string_end = 1'b1;
                        o_out.count             = 2'd1;
                        o_state                 = jsu_pkg::DEC_STATE_RESET;
                    end else if (i_byte == CHAR_BACKSLASH) begin
                        o_state.mode = jsu_pkg::MODE_ESCAPE;
                    end else begin
                        o_out.res[0] = byte_res(i_byte);
                        o_out.count  = 2'd1;
                        o_state.mode = jsu_pkg::MODE_NORMAL;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/json_string_unescape.sv =====
// An accepted byte is registered in the input stage, decoded combinationally,
// and its results are registered in the result buffer before they leave.
// Throughput: one input byte per cycle while the output is ready and each byte
// gives at most one result; the last digit of a \u escape gives up to three
// results, drained one per cycle while the output is ready; the next byte waits.
// Reset (i_rst_n low, synchronous) empties both stages and returns decoding to
// the normal string-body mode with no escape or code point pending.
module json_string_unescape (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    // Input stage: the accepted byte waits here until the result buffer can
    // take everything it produces. This lets a new transaction land while the
    // output side is stalled on an earlier result.
    logic       r_a_valid;
    logic [7:0] r_a_byte;
    logic       r_a_end;

    // Decode state, advanced when the input stage moves into the buffer.
    jsu_pkg::t_dec_state r_state;
    jsu_pkg::t_dec_state n_state;
    jsu_pkg::t_dec_out   dec_out;

    // Result buffer: a short shift line, head at index 0, r_cnt entries live.
    jsu_pkg::t_result r_res [jsu_pkg::MaxResults];
    logic [1:0]       r_cnt;

    logic in_take;
    logic out_take;
    logic buf_free;
    logic a_move;

    jsu_decoder u_decoder (
        .i_byte  (r_a_byte),
        .i_end   (r_a_end),
        .i_state (r_state),
        .o_state (n_state),
        .o_out   (dec_out)
    );

    assign out_take = o_out.valid && o_out.ready;
    // Buffer can reload when empty or when its final entry leaves this cycle.
    assign buf_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign a_move   = r_a_valid && buf_free;
    assign i_in.ready = !r_a_valid || a_move;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_byte <= i_in.data_byte;
            r_a_end  <= i_in.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsu_pkg::DEC_STATE_RESET;
        end else if (a_move) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (a_move) begin
            r_cnt <= dec_out.count;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Results of one byte enter at once; res[0] goes out first.
    always_ff @(posedge i_clk) begin
        if (a_move) begin
            for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
                r_res[i] <= dec_out.res[i];
            end
        end else if (out_take) begin
            for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.out_byte    = r_res[0].out_byte;
    assign o_out.byte_valid  = r_res[0].byte_valid;
    assign o_out.string_end  = r_res[0].string_end;
    assign o_out.truncated   = r_res[0].truncated;
    assign o_out.last_of_run = (r_cnt == 2'd1);

endmodule

// ===== design/jsu_checker.sv =====
`include "json_string_unescape_assert.svh"

module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_string_end,
    input logic       i_truncated,
    input logic       i_last_of_run
);

    // Quote and end-of-stream results stand alone and carry no byte.
    `JSU_ASSERT_NOW(a_end_alone, i_out_valid && (i_string_end || i_truncated), i_last_of_run && !i_byte_valid && !(i_string_end && i_truncated), "end result not a lone marker")

    // A result without a byte carries zero.
    `JSU_ASSERT_NOW(a_zero_byte, i_out_valid && !i_byte_valid, i_out_byte == 8'h00, "out_byte nonzero without byte_valid")

    // The rest of a multi-byte run follows with no gap.
    `JSU_ASSERT_NEXT(a_run_cont, i_out_valid && i_out_ready && !i_last_of_run, i_out_valid && i_byte_valid, "multi-byte run broken")

    // A stalled result holds.
    `JSU_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_last_of_run), "stalled result changed")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_string_end  (o_out.string_end),
    .i_truncated   (o_out.truncated),
    .i_last_of_run (o_out.last_of_run)
);
